// ----- hdl/led_frame_alpha_blend_fill_assert.svh -----
// Assertion macros shared by the frame store modules.
`ifndef LED_FRAME_ALPHA_BLEND_FILL_ASSERT_SVH
`define LED_FRAME_ALPHA_BLEND_FILL_ASSERT_SVH

`ifndef SYNTHESIS

`define LFAB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfab assertion failed");

`define LFAB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfab assertion failed");

`else

`define LFAB_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define LFAB_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/lfab_pkg.sv -----
package lfab_pkg;

  localparam int IDX_W = 11;
  localparam int COL_W = 8;
  localparam int MIX_W = 16;
  localparam logic [COL_W-1:0] COL_MAX = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_BLEND = 2'd0,
    FUNC_SOLID = 2'd1,
    FUNC_DOTS  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CMD_BLEND,
    CMD_BLEND_ERR,
    CMD_SOLID,
    CMD_DOTS
  } cmd_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DONE,
    ST_FILL
  } state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [COL_W-1:0] alpha;
    logic [IDX_W-1:0] step;
    logic [IDX_W-1:0] off;
  } cmd_t;

endpackage

// ----- hdl/lfab_if.sv -----
interface lfab_in_if;
  import lfab_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [IDX_W-1:0] pixel_index;
  logic [COL_W-1:0] red;
  logic [COL_W-1:0] green;
  logic [COL_W-1:0] blue;
  logic [COL_W-1:0] alpha;
  logic [IDX_W-1:0] spacing;
  logic [IDX_W-1:0] start_offset;

  modport source (
    output valid, func, pixel_index, red, green, blue, alpha, spacing, start_offset,
    input  ready
  );

  modport sink (
    input  valid, func, pixel_index, red, green, blue, alpha, spacing, start_offset,
    output ready
  );
endinterface

interface lfab_out_if;
  import lfab_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] slot;
  logic [COL_W-1:0] out_red;
  logic [COL_W-1:0] out_green;
  logic [COL_W-1:0] out_blue;
  logic             index_error;

  modport source (
    output valid, slot, out_red, out_green, out_blue, index_error,
    input  ready
  );

  modport sink (
    input  valid, slot, out_red, out_green, out_blue, index_error,
    output ready
  );
endinterface

// ----- hdl/lfab_ram.sv -----
module lfab_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1050
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/lfab_queue.sv -----
`include "led_frame_alpha_blend_fill_assert.svh"

module lfab_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lfab_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lfab_pkg::cmd_t pop_data
);
  import lfab_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);
  localparam int CNTW = $clog2(QDEPTH + 1);

  cmd_t            entry_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic            push, pop;

  assign push_ready = (count_r != CNTW'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `LFAB_ASSERT_NXT(a_q_drain, clk, rst_n, pop && !push, count_r == $past(count_r) - CNTW'(1))
  `LFAB_ASSERT_NXT(a_q_fill, clk, rst_n, push && !pop, count_r == $past(count_r) + CNTW'(1))
  `LFAB_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, count_r <= CNTW'(QDEPTH))

endmodule

// ----- hdl/lfab_front.sv -----
module lfab_front #(
  parameter int unsigned PIX_TOTAL = 1050
) (
  lfab_in_if.sink        in_ch,
  input  logic           clearing,
  output logic           q_valid,
  input  logic           q_ready,
  output lfab_pkg::cmd_t q_data
);
  import lfab_pkg::*;

  logic keep;

  always_comb begin
    keep          = 1'b0;
    q_data.kind   = CMD_SOLID;
    q_data.idx    = in_ch.pixel_index;
    q_data.red    = in_ch.red;
    q_data.green  = in_ch.green;
    q_data.blue   = in_ch.blue;
    q_data.alpha  = in_ch.alpha;
    q_data.step   = (in_ch.spacing == '0) ? IDX_W'(1) : in_ch.spacing;
    q_data.off    = in_ch.start_offset;
    unique case (func_t'(in_ch.func))
      FUNC_BLEND: begin
        keep        = 1'b1;
        q_data.kind = (32'(in_ch.pixel_index) >= PIX_TOTAL) ? CMD_BLEND_ERR : CMD_BLEND;
      end
      FUNC_SOLID: begin
        keep        = 1'b1;
        q_data.kind = CMD_SOLID;
      end
      FUNC_DOTS: begin
        // offset past the end writes nothing
        keep        = (32'(in_ch.start_offset) < PIX_TOTAL);
        q_data.kind = CMD_DOTS;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = !clearing && q_ready;
  assign q_valid     = in_ch.valid && !clearing && keep;

endmodule

// ----- hdl/lfab_back.sv -----
`include "led_frame_alpha_blend_fill_assert.svh"

module lfab_back #(
  parameter int unsigned PIX_TOTAL = 1050,
  parameter int unsigned NUM_LEFT  = 600
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  lfab_pkg::cmd_t q_data,
  output logic           clearing,
  lfab_out_if.source     out_ch
);
  import lfab_pkg::*;

  localparam int unsigned DEPTH = (PIX_TOTAL > 0) ? PIX_TOTAL : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 2**IDX_W);
  localparam int PIX_W = 3 * COL_W;
  localparam logic [CW-1:0] LEFT_C  = CW'(NUM_LEFT);
  localparam logic [CW-1:0] LEDS_C  = CW'(PIX_TOTAL);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  function automatic logic [AW-1:0] phys(input logic [CW-1:0] i);
    logic [CW-1:0] s;
    s = (i < LEFT_C) ? (LEFT_C - CW'(1) - i) : i;
    return s[AW-1:0];
  endfunction

  function automatic logic [MIX_W-1:0] mix_sum(input logic [COL_W-1:0] fresh,
                                               input logic [COL_W-1:0] old,
                                               input logic [COL_W-1:0] a);
    return MIX_W'(fresh) * MIX_W'(a) + MIX_W'(old) * MIX_W'(COL_MAX - a);
  endfunction

  // floor(x/255), exact over the whole mix range
  function automatic logic [COL_W-1:0] div255(input logic [MIX_W-1:0] x);
    logic [MIX_W:0] t;
    t = (MIX_W+1)'(x) + (MIX_W+1)'(1) + (MIX_W+1)'(x[MIX_W-1:COL_W]);
    return t[MIX_W-1:COL_W];
  endfunction

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;
  logic [CW-1:0]    pos_r, pos_nxt, pos_sum;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             clr_r, clr_nxt;
  logic [MIX_W-1:0] mix_r [3];
  logic [MIX_W-1:0] mix_nxt [3];

  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] o_slot_r;
  logic [COL_W-1:0] o_red_r, o_green_r, o_blue_r;
  logic             o_err_r;
  logic             out_free, load_out;
  logic             blend_err;
  logic [COL_W-1:0] q_red, q_green, q_blue;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [PIX_W-1:0] wdata, rdata;

  lfab_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign blend_err = (cmd_r.kind == CMD_BLEND_ERR);
  assign pos_sum   = pos_r + CW'(step_r);
  assign q_red     = div255(mix_r[0]);
  assign q_green   = div255(mix_r[1]);
  assign q_blue    = div255(mix_r[2]);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    slot_nxt  = slot_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    mix_nxt   = mix_r;
    q_ready   = 1'b0;
    load_out  = 1'b0;
    we        = 1'b0;
    raddr     = phys(CW'(q_data.idx));
    waddr     = slot_r;
    wdata     = {cmd_r.red, cmd_r.green, cmd_r.blue};
    unique case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt  = q_data;
          slot_nxt = raddr;
          unique case (q_data.kind)
            CMD_BLEND:     state_nxt = ST_MIX;
            CMD_BLEND_ERR: state_nxt = ST_DONE;
            CMD_SOLID: begin
              pos_nxt   = '0;
              step_nxt  = IDX_W'(1);
              state_nxt = ST_FILL;
            end
            CMD_DOTS: begin
              pos_nxt   = CW'(q_data.off);
              step_nxt  = q_data.step;
              state_nxt = ST_FILL;
            end
          endcase
        end
      end
      ST_MIX: begin
        mix_nxt[0] = mix_sum(cmd_r.red,   rdata[3*COL_W-1:2*COL_W], cmd_r.alpha);
        mix_nxt[1] = mix_sum(cmd_r.green, rdata[2*COL_W-1:COL_W],   cmd_r.alpha);
        mix_nxt[2] = mix_sum(cmd_r.blue,  rdata[COL_W-1:0],         cmd_r.alpha);
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          we        = !blend_err;
          wdata     = {q_red, q_green, q_blue};
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        we      = 1'b1;
        waddr   = phys(pos_r);
        pos_nxt = pos_sum;
        if (pos_sum >= LEDS_C) begin
          clr_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // reset starts a zero fill over the whole store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      clr_r       <= 1'b1;
      pos_r       <= '0;
      step_r      <= IDX_W'(1);
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    mix_r  <= mix_nxt;
    if (load_out) begin
      o_err_r   <= blend_err;
      o_slot_r  <= blend_err ? '0 : IDX_W'(slot_r);
      o_red_r   <= blend_err ? '0 : q_red;
      o_green_r <= blend_err ? '0 : q_green;
      o_blue_r  <= blend_err ? '0 : q_blue;
    end
  end

  assign clearing           = clr_r;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.slot        = o_slot_r;
  assign out_ch.out_red     = o_red_r;
  assign out_ch.out_green   = o_green_r;
  assign out_ch.out_blue    = o_blue_r;
  assign out_ch.index_error = o_err_r;

  `LFAB_ASSERT_IMP(a_clear_quiet, clk, rst_n, clr_r, !out_valid_r && (state_r == ST_FILL))
  `LFAB_ASSERT_IMP(a_fill_range, clk, rst_n, state_r == ST_FILL, pos_r < DEPTH_C)
  `LFAB_ASSERT_NXT(a_done_emit, clk, rst_n, (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE))

endmodule

// ----- hdl/led_frame_alpha_blend_fill.sv -----
// channel | dir | handshake      | carries
// in_ch   | in  | valid / ready  | func, pixel_index, colour, alpha, spacing, start_offset
// out_ch  | out | valid / ready  | slot, out_red, out_green, out_blue, index_error
//
// Blend: from queue head the steps are accept and RAM read, per-channel multiply, divide and
// write back; the last step waits while the result register is held.
// Solid fill writes every pixel; dots fill writes every spacing-th pixel from offset on,
// one store write per cycle through the single RAM write port.
// After reset the store is zeroed; in_ch.ready stays low meanwhile.
// A two-entry queue decouples input from the store; a held result stalls the back end and
// intake stops once the queue is full.
module led_frame_alpha_blend_fill #(
  parameter int LEDS_PER_STRING = 150,
  parameter int LEFT_STRINGS    = 4,
  parameter int RIGHT_STRINGS   = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  lfab_in_if.sink   in_ch,
  lfab_out_if.source out_ch
);
  import lfab_pkg::*;

  localparam int unsigned NUM_LEFT  = LEFT_STRINGS * LEDS_PER_STRING;
  localparam int unsigned PIX_TOTAL = (LEFT_STRINGS + RIGHT_STRINGS) * LEDS_PER_STRING;

  logic clearing;
  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  lfab_front #(
    .PIX_TOTAL (PIX_TOTAL)
  ) u_front (
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_valid  (push_valid),
    .q_ready  (push_ready),
    .q_data   (push_data)
  );

  lfab_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lfab_back #(
    .PIX_TOTAL (PIX_TOTAL),
    .NUM_LEFT  (NUM_LEFT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_data   (pop_data),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
